// File: src/pci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pci_pkg
// Shared types and constants for the palette color indexer: the probe that
// walks the cell chain, the result record and the control states.
// ----------------------------------------------------------------------------

package pci_pkg;

   localparam int COLOR_W = 32;   // argb pixel width
   localparam int INDEX_W = 8;    // palette index width
   localparam int COUNT_W = 9;    // fill count width, holds 0 to 256

   // probe carried from cell to cell, one cell per cycle
   typedef struct packed {
      logic               live;       // a pixel occupies this slot
      logic [COLOR_W-1:0] color;      // color under search
      logic [COUNT_W-1:0] remaining;  // filled entries still ahead of the probe
      logic               hit;        // a filled entry matched
      logic               placed;     // color was written into a free entry
      logic [INDEX_W-1:0] index;      // entry that matched or took the color
   } probe_type;

   // result record held in the output register
   typedef struct packed {
      logic [INDEX_W-1:0] color_index;
      logic               new_color;
      logic               overflow;
      logic [COUNT_W-1:0] colors_used;
      logic               image_done;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_STALL
   } state_type;

endpackage

`default_nettype wire

// File: src/pci_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pci_if
// Valid/ready channels of the palette color indexer: the pixel request
// channel and the index response channel.
// ----------------------------------------------------------------------------

interface pci_req_if;
   logic                          valid;
   logic                          ready;
   logic [pci_pkg::COLOR_W-1:0]   pixel_color;
   logic                          end_of_image;

   modport source (output valid, output pixel_color, output end_of_image, input ready);
   modport sink   (input valid, input pixel_color, input end_of_image, output ready);
endinterface

interface pci_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pci_pkg::INDEX_W-1:0]   color_index;
   logic                          new_color;
   logic                          overflow;
   logic [pci_pkg::COUNT_W-1:0]   colors_used;
   logic                          image_done;

   modport source (
      output valid, output color_index, output new_color, output overflow,
      output colors_used, output image_done, input ready
   );
   modport sink (
      input valid, input color_index, input new_color, input overflow,
      input colors_used, input image_done, output ready
   );
endinterface

`default_nettype wire

// File: src/pci_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pci_cell
// One palette entry. Compares the passing probe against its entry while the
// entry is below the fill mark, takes the color if it is the first free
// entry, and hands the probe on to the next cell.
// ----------------------------------------------------------------------------

module pci_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire                 clock,
   input  wire                 reset,
   input  pci_pkg::probe_type  probe_in,
   output pci_pkg::probe_type  probe_out
);

   localparam logic [31:0] CELL_ID_FULL = CELL_INDEX;
   localparam logic [pci_pkg::INDEX_W-1:0] CELL_ID = CELL_ID_FULL[pci_pkg::INDEX_W-1:0];

   logic [pci_pkg::COLOR_W-1:0] entry_ff;
   logic [pci_pkg::COLOR_W-1:0] entry_in;
   pci_pkg::probe_type          probe_ff;
   pci_pkg::probe_type          probe_in_next;
   logic                        filled;
   logic                        match;
   logic                        take;

   // entry is filled while the probe still has filled entries ahead
   assign filled = (probe_in.remaining != '0);
   assign match  = probe_in.live && filled && !probe_in.hit
                   && (entry_ff == probe_in.color);
   assign take   = probe_in.live && !filled && !probe_in.hit && !probe_in.placed;

   always_comb begin
      probe_in_next           = probe_in;
      probe_in_next.remaining = filled ? probe_in.remaining - 1'b1 : probe_in.remaining;
      probe_in_next.hit       = probe_in.hit | match;
      probe_in_next.placed    = probe_in.placed | take;
      if (match || take) begin
         probe_in_next.index = CELL_ID;
      end
      entry_in = take ? probe_in.color : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_next;
      end
   end

   assign probe_out = probe_ff;

endmodule

`default_nettype wire

// File: src/palette_color_indexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// palette_color_indexer
// Builds a palette of the distinct argb colors of the current image and
// returns each pixel's palette index, using a chain of compare cells.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ----------------------------------------
//  req_bus  in   valid/ready transfer pixel_color[31:0], end_of_image
//  rsp_bus  out  valid/ready transfer color_index[7:0], new_color, overflow,
//                                     colors_used[8:0], image_done
//
//  flow: a pixel enters cell 0 on its transfer and moves one cell per
//        cycle; its result passes from the chain tail into the output
//        register, and the next pixel is taken only once that result is
//        loaded there, so the chain holds one pixel at a time
//  reset: clears fill count, overflow flag, probes and handshake state;
//         palette entries are not cleared and are only compared once written
//  stalls: a new pixel is taken while the previous result waits in the
//          output register; a result that finds that register still full
//          waits in a holding register and the request side stays closed
// ----------------------------------------------------------------------------

module palette_color_indexer #(
   parameter int PALETTE_DEPTH = 256
) (
   input  wire        clock,
   input  wire        reset,
   pci_req_if.sink    req_bus,
   pci_rsp_if.source  rsp_bus
);

   localparam logic [31:0] DEPTH_FULL = PALETTE_DEPTH;
   localparam logic [pci_pkg::COUNT_W-1:0] DEPTH_COUNT = DEPTH_FULL[pci_pkg::COUNT_W-1:0];

   // control state
   pci_pkg::state_type state_ff;
   pci_pkg::state_type state_in;

   // palette bookkeeping
   logic [pci_pkg::COUNT_W-1:0] fill_count_ff;
   logic [pci_pkg::COUNT_W-1:0] fill_count_in;
   logic                        overflow_ff;
   logic                        overflow_in;
   logic                        eoi_ff;
   logic                        eoi_in;

   // output register and holding register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   pci_pkg::result_type  rsp_data_ff;
   pci_pkg::result_type  rsp_data_in;
   pci_pkg::result_type  pend_data_ff;
   pci_pkg::result_type  pend_data_in;

   // chain
   pci_pkg::probe_type   probe_head;
   pci_pkg::probe_type   probe_w [PALETTE_DEPTH+1];
   pci_pkg::probe_type   tail;
   pci_pkg::result_type  result;

   logic                        req_xfer;
   logic                        out_free;
   logic                        load_rsp;
   logic                        miss_full;
   logic [pci_pkg::COUNT_W-1:0] count_after;

   assign req_xfer = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // ---------------------------------------------------------------------
   // probe injection: the count of filled entries rides along with the pixel
   // ---------------------------------------------------------------------
   always_comb begin
      probe_head           = '0;
      probe_head.live      = req_xfer;
      probe_head.color     = req_bus.pixel_color;
      probe_head.remaining = fill_count_ff;
   end

   assign probe_w[0] = probe_head;

   genvar gi;
   generate
      for (gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_cell
         pci_cell #(
            .CELL_INDEX (gi)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .probe_in  (probe_w[gi]),
            .probe_out (probe_w[gi+1])
         );
      end
   endgenerate

   assign tail = probe_w[PALETTE_DEPTH];

   // ---------------------------------------------------------------------
   // result at the chain tail: hit, append, or overflow on a full palette
   // ---------------------------------------------------------------------
   assign miss_full   = !tail.hit && !tail.placed;
   assign count_after = fill_count_ff + {{(pci_pkg::COUNT_W-1){1'b0}}, tail.placed};

   always_comb begin
      result.color_index = miss_full ? '0 : tail.index;
      result.new_color   = tail.placed;
      result.overflow    = overflow_ff | miss_full;
      result.colors_used = count_after;
      result.image_done  = eoi_ff;
   end

   // palette count and overflow flag, cleared after an end-of-image pixel
   always_comb begin
      fill_count_in = fill_count_ff;
      overflow_in   = overflow_ff;
      if (tail.live) begin
         fill_count_in = eoi_ff ? '0 : count_after;
         overflow_in   = eoi_ff ? 1'b0 : result.overflow;
      end
      eoi_in       = req_xfer ? req_bus.end_of_image : eoi_ff;
      pend_data_in = tail.live ? result : pend_data_ff;
   end

   // ---------------------------------------------------------------------
   // control: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pci_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = pci_pkg::ST_SEARCH;
            end
         end
         pci_pkg::ST_SEARCH: begin
            if (tail.live) begin
               state_in = out_free ? pci_pkg::ST_IDLE : pci_pkg::ST_STALL;
            end
         end
         pci_pkg::ST_STALL: begin
            if (out_free) begin
               state_in = pci_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pci_pkg::ST_IDLE;
         end
      endcase
   end

   // control: outputs
   always_comb begin
      req_bus.ready = 1'b0;
      load_rsp      = 1'b0;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         pci_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         pci_pkg::ST_SEARCH: begin
            load_rsp    = tail.live && out_free;
            rsp_data_in = load_rsp ? result : rsp_data_ff;
         end
         pci_pkg::ST_STALL: begin
            load_rsp    = out_free;
            rsp_data_in = load_rsp ? pend_data_ff : rsp_data_ff;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pci_pkg::ST_IDLE;
         fill_count_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      eoi_ff       <= eoi_in;
      rsp_data_ff  <= rsp_data_in;
      pend_data_ff <= pend_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.color_index = rsp_data_ff.color_index;
   assign rsp_bus.new_color   = rsp_data_ff.new_color;
   assign rsp_bus.overflow    = rsp_data_ff.overflow;
   assign rsp_bus.colors_used = rsp_data_ff.colors_used;
   assign rsp_bus.image_done  = rsp_data_ff.image_done;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // a probe only leaves the chain while its pixel is being searched
   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      tail.live |-> (state_ff == pci_pkg::ST_SEARCH))
      else $error("probe left chain outside search");

   // the fill count never passes the palette depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= DEPTH_COUNT)
      else $error("fill count beyond palette depth");

   // a color is either found or placed, never both
   a_hit_or_place: assert property (@(posedge clock) disable iff (reset)
      tail.live |-> !(tail.hit && tail.placed))
      else $error("probe both hit and placed");

   // an accepted pixel starts a search on the next cycle
   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == pci_pkg::ST_SEARCH))
      else $error("accepted pixel did not start search");

   // a new entry always leaves at least one color counted
   a_new_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.new_color) |-> (rsp_data_ff.colors_used != '0))
      else $error("new color with empty palette count");

endmodule

`default_nettype wire
